// ===== hdl/bf_pkg.sv =====
// Shared types, codes and defaults of the Brainfuck machine.
`default_nettype none

package bf_pkg;

  // Default sizes of the stores.
  localparam int unsigned CodeDepthDef  = 1024;
  localparam int unsigned TapeDepthDef  = 4096;
  localparam int unsigned CellBitsDef   = 8;
  localparam int unsigned StackDepthDef = 64;

  // Fixed field widths.
  localparam int unsigned ModeW    = 2;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned StatusW  = 4;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned EofW     = 2;

  // Register indexes and reset values.
  localparam logic [CfgIdxW-1:0] CfgStepLimit = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgEofPolicy = 8'd1;
  localparam logic [CfgDataW-1:0] StepLimitRst = 32'd1000000;

  // End-of-input policies; the remaining codes leave the cell alone.
  localparam logic [EofW-1:0] EofOnes = 2'd0;
  localparam logic [EofW-1:0] EofZero = 2'd1;

  // Instruction characters.
  localparam logic [7:0] ChRight = 8'h3E;
  localparam logic [7:0] ChLeft  = 8'h3C;
  localparam logic [7:0] ChInc   = 8'h2B;
  localparam logic [7:0] ChDec   = 8'h2D;
  localparam logic [7:0] ChOut   = 8'h2E;
  localparam logic [7:0] ChIn    = 8'h2C;
  localparam logic [7:0] ChOpen  = 8'h5B;
  localparam logic [7:0] ChClose = 8'h5D;

  typedef enum logic [ModeW-1:0] {
    MODE_APPEND = 2'd0,
    MODE_CLEAR  = 2'd1,
    MODE_RUN    = 2'd2,
    MODE_RUN_B  = 2'd3
  } bf_mode_e;

  typedef enum logic [StatusW-1:0] {
    STS_LOADED  = 4'd0,
    STS_FULL    = 4'd1,
    STS_OUTPUT  = 4'd2,
    STS_INPUT   = 4'd3,
    STS_HALTED  = 4'd4,
    STS_LIMIT   = 4'd5,
    STS_BRACKET = 4'd6,
    STS_CLEARED = 4'd7,
    STS_DEEP    = 4'd8
  } bf_status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_EXEC,
    ST_POP,
    ST_SCAN,
    ST_SCAN_CHK,
    ST_RESP
  } bf_state_e;

  // One result word.
  typedef struct packed {
    bf_status_e       status;
    logic [ByteW-1:0] out_byte;
  } bf_res_t;

endpackage

`default_nettype wire

// ===== hdl/bf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module bf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hdl/bf_core.sv =====
// Sequencer that fetches, decodes and executes instructions against the RAMs.
`default_nettype none

module bf_core #(
  parameter int unsigned CodeDepth  = bf_pkg::CodeDepthDef,
  parameter int unsigned TapeDepth  = bf_pkg::TapeDepthDef,
  parameter int unsigned CellBits   = bf_pkg::CellBitsDef,
  parameter int unsigned StackDepth = bf_pkg::StackDepthDef,
  localparam int unsigned PA = $clog2(CodeDepth),
  localparam int unsigned TA = $clog2(TapeDepth),
  localparam int unsigned SA = $clog2(StackDepth)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Input word
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [bf_pkg::ModeW-1:0]      mode_i,
  input  wire logic [bf_pkg::ByteW-1:0]      code_byte_i,
  input  wire logic [bf_pkg::ByteW-1:0]      in_byte_i,
  input  wire logic                          in_eof_i,
  // Register writes
  input  wire logic                          cfg_we_i,
  input  wire logic [bf_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [bf_pkg::CfgDataW-1:0]   cfg_data_i,
  // Result toward the output register
  output logic                               res_valid_o,
  output bf_pkg::bf_res_t                    res_o,
  input  wire logic                          slot_free_i,
  // Program RAM
  output logic                               prog_we_o,
  output logic [PA-1:0]                      prog_waddr_o,
  output logic [bf_pkg::ByteW-1:0]           prog_wdata_o,
  output logic [PA-1:0]                      prog_raddr_o,
  input  wire logic [bf_pkg::ByteW-1:0]      prog_rdata_i,
  // Tape RAM
  output logic                               tape_we_o,
  output logic [TA-1:0]                      tape_waddr_o,
  output logic [CellBits-1:0]                tape_wdata_o,
  output logic [TA-1:0]                      tape_raddr_o,
  input  wire logic [CellBits-1:0]           tape_rdata_i,
  // Loop stack RAM
  output logic                               stk_we_o,
  output logic [SA-1:0]                      stk_waddr_o,
  output logic [PA-1:0]                      stk_wdata_o,
  output logic [SA-1:0]                      stk_raddr_o,
  input  wire logic [PA-1:0]                 stk_rdata_i
);

  import bf_pkg::*;

  localparam int unsigned LW = PA + 1;
  localparam int unsigned DW = SA + 1;

  bf_state_e           state_q, state_d;
  logic [LW-1:0]       pc_q, pc_d;
  logic [LW-1:0]       len_q, len_d;
  logic [TA-1:0]       tp_q, tp_d;
  logic [DW-1:0]       depth_q, depth_d;
  logic                await_q, await_d;
  logic [CfgDataW-1:0] steps_q, steps_d;
  logic [LW-1:0]       scan_q, scan_d;
  logic [LW-1:0]       nest_q, nest_d;
  logic [TA-1:0]       clr_q, clr_d;
  logic                clr_pend_q, clr_pend_d;
  logic [CfgDataW-1:0] limit_q;
  logic [EofW-1:0]     eof_q;
  bf_res_t             res_q, res_d;
  logic [LW-1:0]       pc_inc;

  assign pc_inc = pc_q + LW'(1);
  assign res_o  = res_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= StepLimitRst;
      eof_q   <= EofOnes;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CfgStepLimit) begin
        limit_q <= cfg_data_i;
      end else if (cfg_index_i == CfgEofPolicy) begin
        eof_q <= cfg_data_i[EofW-1:0];
      end
    end
  end

  // State and machine registers; reset begins with a tape clearing pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      pc_q       <= '0;
      len_q      <= '0;
      tp_q       <= '0;
      depth_q    <= '0;
      await_q    <= 1'b0;
      steps_q    <= '0;
      scan_q     <= '0;
      nest_q     <= '0;
      clr_q      <= '0;
      clr_pend_q <= 1'b0;
      res_q      <= '{status: STS_LOADED, out_byte: '0};
    end else begin
      state_q    <= state_d;
      pc_q       <= pc_d;
      len_q      <= len_d;
      tp_q       <= tp_d;
      depth_q    <= depth_d;
      await_q    <= await_d;
      steps_q    <= steps_d;
      scan_q     <= scan_d;
      nest_q     <= nest_d;
      clr_q      <= clr_d;
      clr_pend_q <= clr_pend_d;
      res_q      <= res_d;
    end
  end

  // Next state, RAM control and result.
  always_comb begin
    state_d      = state_q;
    pc_d         = pc_q;
    len_d        = len_q;
    tp_d         = tp_q;
    depth_d      = depth_q;
    await_d      = await_q;
    steps_d      = steps_q;
    scan_d       = scan_q;
    nest_d       = nest_q;
    clr_d        = clr_q;
    clr_pend_d   = clr_pend_q;
    res_d        = res_q;
    in_stall_o   = 1'b1;
    res_valid_o  = 1'b0;
    prog_we_o    = 1'b0;
    prog_waddr_o = len_q[PA-1:0];
    prog_wdata_o = code_byte_i;
    prog_raddr_o = pc_q[PA-1:0];
    tape_we_o    = 1'b0;
    tape_waddr_o = tp_q;
    tape_wdata_o = '0;
    tape_raddr_o = tp_q;
    stk_we_o     = 1'b0;
    stk_waddr_o  = depth_q[SA-1:0];
    stk_wdata_o  = pc_q[PA-1:0];
    stk_raddr_o  = SA'(depth_q - DW'(1));

    unique case (state_q)
      // Zero one tape cell per cycle.
      ST_CLEAR: begin
        tape_we_o    = 1'b1;
        tape_waddr_o = clr_q;
        clr_d        = clr_q + TA'(1);
        if (clr_q == TA'(TapeDepth - 1)) begin
          clr_d   = '0;
          state_d = clr_pend_q ? ST_RESP : ST_IDLE;
        end
      end

      // Take the next input word.
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          res_d.out_byte = '0;
          unique case (bf_mode_e'(mode_i))
            MODE_APPEND: begin
              if (len_q == LW'(CodeDepth)) begin
                res_d.status = STS_FULL;
              end else begin
                prog_we_o    = 1'b1;
                len_d        = len_q + LW'(1);
                res_d.status = STS_LOADED;
              end
              state_d = ST_RESP;
            end
            MODE_CLEAR: begin
              len_d        = '0;
              pc_d         = '0;
              tp_d         = '0;
              depth_d      = '0;
              await_d      = 1'b0;
              clr_pend_d   = 1'b1;
              res_d.status = STS_CLEARED;
              state_d      = ST_CLEAR;
            end
            default: begin
              // Store the pending input byte before running on.
              if (await_q) begin
                await_d = 1'b0;
                if (!in_eof_i) begin
                  tape_we_o    = 1'b1;
                  tape_wdata_o = CellBits'(in_byte_i);
                end else if (eof_q == EofOnes) begin
                  tape_we_o    = 1'b1;
                  tape_wdata_o = '1;
                end else if (eof_q == EofZero) begin
                  tape_we_o    = 1'b1;
                end
              end
              steps_d = '0;
              state_d = ST_FETCH;
            end
          endcase
        end
      end

      // Check the stop conditions and read the instruction and the cell.
      ST_FETCH: begin
        if (pc_q >= len_q) begin
          res_d.status = (depth_q != '0) ? STS_BRACKET : STS_HALTED;
          state_d      = ST_RESP;
        end else if (steps_q >= limit_q) begin
          res_d.status = STS_LIMIT;
          state_d      = ST_RESP;
        end else begin
          steps_d = steps_q + CfgDataW'(1);
          state_d = ST_EXEC;
        end
      end

      // Execute one instruction.
      ST_EXEC: begin
        pc_d    = pc_inc;
        state_d = ST_FETCH;
        case (prog_rdata_i)
          ChRight: begin
            if (tp_q != TA'(TapeDepth - 1)) begin
              tp_d = tp_q + TA'(1);
            end
          end
          ChLeft: begin
            if (tp_q != '0) begin
              tp_d = tp_q - TA'(1);
            end
          end
          ChInc: begin
            tape_we_o    = 1'b1;
            tape_wdata_o = tape_rdata_i + CellBits'(1);
          end
          ChDec: begin
            tape_we_o    = 1'b1;
            tape_wdata_o = tape_rdata_i - CellBits'(1);
          end
          ChOut: begin
            res_d.status   = STS_OUTPUT;
            res_d.out_byte = tape_rdata_i[ByteW-1:0];
            state_d        = ST_RESP;
          end
          ChIn: begin
            await_d      = 1'b1;
            res_d.status = STS_INPUT;
            state_d      = ST_RESP;
          end
          ChOpen: begin
            if (tape_rdata_i != '0) begin
              if (depth_q >= DW'(StackDepth)) begin
                pc_d         = pc_q;
                res_d.status = STS_DEEP;
                state_d      = ST_RESP;
              end else begin
                stk_we_o = 1'b1;
                depth_d  = depth_q + DW'(1);
              end
            end else begin
              // Search forward for the matching close bracket.
              pc_d    = pc_q;
              scan_d  = pc_inc;
              nest_d  = '0;
              state_d = ST_SCAN;
            end
          end
          ChClose: begin
            if (depth_q == '0) begin
              pc_d         = pc_q;
              res_d.status = STS_BRACKET;
              state_d      = ST_RESP;
            end else if (tape_rdata_i != '0) begin
              pc_d    = pc_q;
              state_d = ST_POP;
            end else begin
              depth_d = depth_q - DW'(1);
            end
          end
          default: begin
          end
        endcase
      end

      // Jump back behind the open bracket on top of the stack.
      ST_POP: begin
        pc_d    = LW'(stk_rdata_i) + LW'(1);
        state_d = ST_FETCH;
      end

      // Read the next byte of the bracket search.
      ST_SCAN: begin
        prog_raddr_o = scan_q[PA-1:0];
        if (scan_q >= len_q) begin
          res_d.status = STS_BRACKET;
          state_d      = ST_RESP;
        end else begin
          state_d = ST_SCAN_CHK;
        end
      end

      // Track the nesting of the bracket search.
      ST_SCAN_CHK: begin
        scan_d  = scan_q + LW'(1);
        state_d = ST_SCAN;
        if (prog_rdata_i == ChOpen) begin
          nest_d = nest_q + LW'(1);
        end else if (prog_rdata_i == ChClose) begin
          if (nest_q == '0) begin
            pc_d    = scan_q + LW'(1);
            state_d = ST_FETCH;
          end else begin
            nest_d = nest_q - LW'(1);
          end
        end
      end

      // Hand the result word to the output register.
      ST_RESP: begin
        res_valid_o = 1'b1;
        if (slot_free_i) begin
          clr_pend_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/brainfuck_interpreter.sv =====
// Top level of the Brainfuck machine: RAMs, sequencer and output register.
//
// Usage: each input word carries a mode (append a program byte, clear the
// machine, or run) plus the program byte, an input byte and an end-of-input
// flag. Every accepted word yields exactly one result word with a status
// and, for an output instruction, the output byte. Both channels use valid
// and stall; a word moves when valid is high and stall is low.
// The configuration channel (valid/ready, always ready) writes the step
// limit (index 0) and the end-of-input policy (index 1). The user must
// write them only while idle; the block itself does not enforce this.
// A run executes each instruction as a fetch state, reading the program
// and tape RAMs, and an execute state; a jump back adds a pop state and
// a forward bracket search a scan and a check state for each byte.
// One word is processed at a time; the next word is accepted once the
// result sits in the output register, even while the receiver stalls it.
// Reset, and every clear word, zeroes all TapeDepth cells (4096 by
// default) of the tape in a pass during which input is stalled.
// A stalled result stays on the outputs unchanged.
`default_nettype none

module brainfuck_interpreter #(
  parameter int unsigned CodeDepth  = bf_pkg::CodeDepthDef,
  parameter int unsigned TapeDepth  = bf_pkg::TapeDepthDef,
  parameter int unsigned CellBits   = bf_pkg::CellBitsDef,
  parameter int unsigned StackDepth = bf_pkg::StackDepthDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [bf_pkg::ModeW-1:0]    mode_i,
  input  wire logic [bf_pkg::ByteW-1:0]    code_byte_i,
  input  wire logic [bf_pkg::ByteW-1:0]    in_byte_i,
  input  wire logic                        in_eof_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [bf_pkg::StatusW-1:0]       status_o,
  output logic [bf_pkg::ByteW-1:0]         out_byte_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [bf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [bf_pkg::CfgDataW-1:0] cfg_data_i
);

  import bf_pkg::*;

  localparam int unsigned PA = $clog2(CodeDepth);
  localparam int unsigned TA = $clog2(TapeDepth);
  localparam int unsigned SA = $clog2(StackDepth);

  logic                res_valid;
  bf_res_t             res;
  logic                slot_free;
  logic                out_valid_q;
  bf_res_t             out_q;
  logic                prog_we;
  logic [PA-1:0]       prog_waddr, prog_raddr;
  logic [ByteW-1:0]    prog_wdata, prog_rdata;
  logic                tape_we;
  logic [TA-1:0]       tape_waddr, tape_raddr;
  logic [CellBits-1:0] tape_wdata, tape_rdata;
  logic                stk_we;
  logic [SA-1:0]       stk_waddr, stk_raddr;
  logic [PA-1:0]       stk_wdata, stk_rdata;

  assign cfg_ready_o = 1'b1;

  bf_core #(
    .CodeDepth (CodeDepth),
    .TapeDepth (TapeDepth),
    .CellBits  (CellBits),
    .StackDepth(StackDepth)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .code_byte_i (code_byte_i),
    .in_byte_i   (in_byte_i),
    .in_eof_i    (in_eof_i),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .res_valid_o (res_valid),
    .res_o       (res),
    .slot_free_i (slot_free),
    .prog_we_o   (prog_we),
    .prog_waddr_o(prog_waddr),
    .prog_wdata_o(prog_wdata),
    .prog_raddr_o(prog_raddr),
    .prog_rdata_i(prog_rdata),
    .tape_we_o   (tape_we),
    .tape_waddr_o(tape_waddr),
    .tape_wdata_o(tape_wdata),
    .tape_raddr_o(tape_raddr),
    .tape_rdata_i(tape_rdata),
    .stk_we_o    (stk_we),
    .stk_waddr_o (stk_waddr),
    .stk_wdata_o (stk_wdata),
    .stk_raddr_o (stk_raddr),
    .stk_rdata_i (stk_rdata)
  );

  bf_ram #(.Width(ByteW), .Depth(CodeDepth)) u_prog_ram (
    .clk_i  (clk_i),
    .we_i   (prog_we),
    .waddr_i(prog_waddr),
    .wdata_i(prog_wdata),
    .raddr_i(prog_raddr),
    .rdata_o(prog_rdata)
  );

  bf_ram #(.Width(CellBits), .Depth(TapeDepth)) u_tape_ram (
    .clk_i  (clk_i),
    .we_i   (tape_we),
    .waddr_i(tape_waddr),
    .wdata_i(tape_wdata),
    .raddr_i(tape_raddr),
    .rdata_o(tape_rdata)
  );

  bf_ram #(.Width(PA), .Depth(StackDepth)) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (stk_we),
    .waddr_i(stk_waddr),
    .wdata_i(stk_wdata),
    .raddr_i(stk_raddr),
    .rdata_o(stk_rdata)
  );

  // Output register: free when empty or being taken this cycle.
  assign slot_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && slot_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && slot_free) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_q.status;
  assign out_byte_o  = out_q.out_byte;

endmodule

`default_nettype wire

// ===== hdl/bf_checker.sv =====
// Port-level checker for the Brainfuck machine and its bind statement.
`default_nettype none

module bf_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_stall_o,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic [bf_pkg::StatusW-1:0]  status_o,
  input wire logic [bf_pkg::ByteW-1:0]    out_byte_o
);

  import bf_pkg::*;

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(out_byte_o))
    else $error("stalled result changed");

  // Only an output instruction carries a nonzero byte.
  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STS_OUTPUT |-> out_byte_o == '0)
    else $error("out_byte set without output status");

  // Status codes stay within the defined set.
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= STS_DEEP)
    else $error("undefined status code");

  // One word at a time: after an accept the input is stalled.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second word accepted while busy");

endmodule

bind brainfuck_interpreter bf_checker u_bf_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .status_o   (status_o),
  .out_byte_o (out_byte_o)
);

`default_nettype wire
